// ===== hdl/ppgt_pkg.sv =====
// Package with codes, timing constants and shared types of the presence and gesture tracker.
`timescale 1ns / 1ps

package ppgt_pkg;

   // Presence state codes, as shown on the result channel.
   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_APPROACH = 2'd1;
   localparam logic [1:0] ST_NEAR     = 2'd2;
   localparam logic [1:0] ST_LEFT     = 2'd3;

   // Presence event codes.
   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_DETECTED    = 3'd1;
   localparam logic [2:0] EV_APPROACHING = 3'd2;
   localparam logic [2:0] EV_LEFT        = 3'd3;
   localparam logic [2:0] EV_ERROR       = 3'd4;

   // Gesture event codes.
   localparam logic [1:0] G_NONE     = 2'd0;
   localparam logic [1:0] G_HOVER    = 2'd1;
   localparam logic [1:0] G_APPROACH = 2'd2;
   localparam logic [1:0] G_RETREAT  = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_MAX_VALID       = 3'd0;
   localparam logic [2:0] REG_NEARBY_ENTER    = 3'd1;
   localparam logic [2:0] REG_NEARBY_EXIT     = 3'd2;
   localparam logic [2:0] REG_APPROACH_ENTER  = 3'd3;
   localparam logic [2:0] REG_APPROACH_EXIT   = 3'd4;
   localparam logic [2:0] REG_CONFIRM         = 3'd5;
   localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd6;
   localparam logic [2:0] REG_GESTURES_EN     = 3'd7;

   // Gesture timing and distance constants, and the presence candidate count limit.
   localparam logic signed [16:0] MOVE_THRESHOLD_MM = 17'sd250;
   localparam logic signed [16:0] HOVER_JITTER_MM   = 17'sd45;
   localparam logic [31:0]        MOVE_WINDOW_MS    = 32'd450;
   localparam logic [31:0]        HOVER_HOLD_MS     = 32'd1000;
   localparam logic [31:0]        COOLDOWN_MS       = 32'd700;
   localparam logic [7:0]         COUNT_MAX         = 8'd255;

   typedef struct packed {
      logic [15:0] reference_mm;
      logic [31:0] reference_time;
      logic [31:0] hover_start;
      logic        hover_reported;
      logic [31:0] cooldown_until;
   } gesture_state_type;

endpackage

// ===== hdl/ppgt_gesture.sv =====
// Gesture detector: next gesture tracking state and gesture code for one sample.
`timescale 1ns / 1ps

module ppgt_gesture import ppgt_pkg::*; (
   input  logic [31:0]       now_ms,
   input  logic [15:0]       distance_mm,
   input  logic [15:0]       max_valid_mm,
   input  logic [15:0]       nearby_enter_mm,
   input  gesture_state_type state_cur,
   output gesture_state_type state_next,
   output logic [1:0]        gesture
);

   logic signed [16:0] delta;
   logic               jitter_ok;
   logic               big_move;
   logic               in_window;
   logic               in_cooldown;
   logic [31:0]        hover_age;

   assign delta = $signed({1'b0, distance_mm}) - $signed({1'b0, state_cur.reference_mm});
   assign jitter_ok = (delta <= HOVER_JITTER_MM) && (delta >= -HOVER_JITTER_MM);
   assign big_move = (delta <= -MOVE_THRESHOLD_MM) || (delta >= MOVE_THRESHOLD_MM);
   assign in_window = (now_ms - state_cur.reference_time) <= MOVE_WINDOW_MS;
   assign in_cooldown = now_ms < state_cur.cooldown_until;
   assign hover_age = now_ms - state_cur.hover_start;

   always_comb begin
      state_next = state_cur;
      gesture = G_NONE;
      if (distance_mm == 16'd0 || distance_mm > max_valid_mm) begin
         state_next.reference_mm = 16'd0;
         state_next.hover_start = 32'd0;
         state_next.hover_reported = 1'b0;
      end else if (state_cur.reference_mm == 16'd0) begin
         state_next.reference_mm = distance_mm;
         state_next.reference_time = now_ms;
         state_next.hover_start = now_ms;
      end else begin
         if (jitter_ok) begin
            // An unset hover start restarts at this tick, so it cannot report yet.
            if (state_cur.hover_start == 32'd0) begin
               state_next.hover_start = now_ms;
            end else if (!state_cur.hover_reported && distance_mm <= nearby_enter_mm &&
                         hover_age >= HOVER_HOLD_MS) begin
               state_next.hover_reported = 1'b1;
               gesture = G_HOVER;
            end
         end else begin
            state_next.hover_start = now_ms;
            state_next.hover_reported = 1'b0;
         end

         if (in_cooldown) begin
            if (!in_window) begin
               state_next.reference_mm = distance_mm;
               state_next.reference_time = now_ms;
            end
         end else if (in_window) begin
            if (big_move) begin
               gesture = delta[16] ? G_APPROACH : G_RETREAT;
               state_next.cooldown_until = now_ms + COOLDOWN_MS;
               state_next.reference_mm = distance_mm;
               state_next.reference_time = now_ms;
            end
         end else begin
            state_next.reference_mm = distance_mm;
            state_next.reference_time = now_ms;
         end
      end
   end

endmodule

// ===== hdl/proximity_presence_gesture_tracker_top.sv =====
// Top level of the proximity presence and gesture tracker.
//
// The req channel carries one update tick per beat: a wrapping millisecond
// timestamp, a range sample and a sensor timeout flag. Each accepted beat
// produces exactly one rsp beat with the committed presence state, the
// presence and gesture events, the event distance and the committed distance.
// All of the work for a tick is done in the cycle it is accepted, and the
// result is registered, so a response appears in the cycle after acceptance.
// A new tick can be accepted every cycle while the receiver takes each
// result; throughput is one beat per cycle, set by the single result register.
// When the receiver stalls, the result register holds its beat and req_ready
// drops until that beat is taken; ready returns in the same cycle that
// rsp_ready is seen high.
// Configuration registers are written through the csr port, one per cycle,
// and should only be changed while no tick is in flight.
// Synchronous reset restores all configuration defaults, clears the
// presence and gesture tracking state and empties the result register.
`timescale 1ns / 1ps

module proximity_presence_gesture_tracker_top import ppgt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_distance_mm,
   input  logic        req_sensor_timeout,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_presence_state,
   output logic [2:0]  rsp_presence_event,
   output logic [1:0]  rsp_gesture_event,
   output logic [15:0] rsp_event_distance_mm,
   output logic [15:0] rsp_committed_distance_mm,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [15:0] max_valid_ff;
   logic [15:0] nearby_enter_ff;
   logic [15:0] nearby_exit_ff;
   logic [15:0] approach_enter_ff;
   logic [15:0] approach_exit_ff;
   logic [7:0]  confirm_ff;
   logic [15:0] interval_ff;
   logic        gestures_en_ff;

   // Tracking state.
   logic [1:0]        cur_state_ff, cur_state_in;
   logic [1:0]        cand_state_ff, cand_state_in;
   logic [7:0]        cand_count_ff, cand_count_in;
   logic [31:0]       last_time_ff, last_time_in;
   logic [15:0]       committed_ff, committed_in;
   gesture_state_type gest_ff, gest_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  out_state_ff, out_state_in;
   logic [2:0]  out_pev_ff, out_pev_in;
   logic [1:0]  out_gev_ff, out_gev_in;
   logic [15:0] out_edist_ff, out_edist_in;
   logic [15:0] out_committed_ff, out_committed_in;

   gesture_state_type gest_next;
   logic [1:0]        gest_code;
   logic              accept;

   logic [1:0]  cur;
   logic [1:0]  seen;
   logic [7:0]  count;
   logic [1:0]  cand;
   logic        gated_ok;
   logic        mm_valid;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_presence_state = out_state_ff;
   assign rsp_presence_event = out_pev_ff;
   assign rsp_gesture_event = out_gev_ff;
   assign rsp_event_distance_mm = out_edist_ff;
   assign rsp_committed_distance_mm = out_committed_ff;

   ppgt_gesture u_gesture (
      .now_ms          (req_now_ms),
      .distance_mm     (req_distance_mm),
      .max_valid_mm    (max_valid_ff),
      .nearby_enter_mm (nearby_enter_ff),
      .state_cur       (gest_ff),
      .state_next      (gest_next),
      .gesture         (gest_code)
   );

   assign gated_ok = (req_now_ms - last_time_ff) >= {16'd0, interval_ff};
   assign mm_valid = (req_distance_mm != 16'd0) && (req_distance_mm <= max_valid_ff);
   // A LEFT state from the previous tick collapses before anything else.
   assign cur = (cur_state_ff == ST_LEFT) ? ST_NONE : cur_state_ff;
   assign cand = (cur_state_ff == ST_LEFT) ? ST_NONE : cand_state_ff;
   assign count = (cur_state_ff == ST_LEFT) ? 8'd0 : cand_count_ff;

   // Hysteresis classification against the collapsed current state.
   always_comb begin
      seen = ST_NONE;
      if (mm_valid) begin
         case (cur)
            ST_NEAR: begin
               if (req_distance_mm > approach_exit_ff) seen = ST_NONE;
               else if (req_distance_mm > nearby_exit_ff) seen = ST_APPROACH;
               else seen = ST_NEAR;
            end
            ST_APPROACH: begin
               if (req_distance_mm <= nearby_enter_ff) seen = ST_NEAR;
               else if (req_distance_mm > approach_exit_ff) seen = ST_NONE;
               else seen = ST_APPROACH;
            end
            default: begin
               if (req_distance_mm <= nearby_enter_ff) seen = ST_NEAR;
               else if (req_distance_mm <= approach_enter_ff) seen = ST_APPROACH;
               else seen = ST_NONE;
            end
         endcase
      end
   end

   always_comb begin
      cur_state_in = cur_state_ff;
      cand_state_in = cand_state_ff;
      cand_count_in = cand_count_ff;
      last_time_in = last_time_ff;
      committed_in = committed_ff;
      gest_in = gest_ff;
      out_pev_in = EV_NONE;
      out_gev_in = G_NONE;
      out_edist_in = 16'd0;
      if (accept) begin
         cur_state_in = cur;
         cand_state_in = cand;
         cand_count_in = count;
         if (gated_ok) begin
            last_time_in = req_now_ms;
            if (req_sensor_timeout) begin
               out_pev_in = EV_ERROR;
            end else begin
               if (gestures_en_ff) begin
                  gest_in = gest_next;
                  out_gev_in = gest_code;
                  if (gest_code != G_NONE) out_edist_in = req_distance_mm;
               end
               if (seen == cand) begin
                  if (count != COUNT_MAX) cand_count_in = count + 8'd1;
               end else begin
                  cand_state_in = seen;
                  cand_count_in = 8'd1;
               end
               if (cand_count_in >= confirm_ff && seen != cur) begin
                  cur_state_in = seen;
                  committed_in = (seen == ST_NONE) ? 16'd0 : req_distance_mm;
                  if (seen == ST_NEAR) begin
                     out_pev_in = EV_DETECTED;
                     out_edist_in = req_distance_mm;
                  end else if (seen == ST_APPROACH) begin
                     if (cur == ST_NONE) begin
                        out_pev_in = EV_APPROACHING;
                        out_edist_in = req_distance_mm;
                     end
                  end else if (cur != ST_NONE) begin
                     cur_state_in = ST_LEFT;
                     out_pev_in = EV_LEFT;
                     out_edist_in = 16'd0;
                  end
               end
            end
         end
      end
      out_state_in = cur_state_in;
      out_committed_in = committed_in;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_valid_ff <= 16'd1200;
         nearby_enter_ff <= 16'd300;
         nearby_exit_ff <= 16'd400;
         approach_enter_ff <= 16'd800;
         approach_exit_ff <= 16'd1000;
         confirm_ff <= 8'd3;
         interval_ff <= 16'd50;
         gestures_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MAX_VALID:       max_valid_ff <= csr_wdata;
            REG_NEARBY_ENTER:    nearby_enter_ff <= csr_wdata;
            REG_NEARBY_EXIT:     nearby_exit_ff <= csr_wdata;
            REG_APPROACH_ENTER:  approach_enter_ff <= csr_wdata;
            REG_APPROACH_EXIT:   approach_exit_ff <= csr_wdata;
            REG_CONFIRM:         confirm_ff <= csr_wdata[7:0];
            REG_SAMPLE_INTERVAL: interval_ff <= csr_wdata;
            REG_GESTURES_EN:     gestures_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff <= ST_NONE;
         cand_state_ff <= ST_NONE;
         cand_count_ff <= 8'd0;
         last_time_ff <= 32'd0;
         committed_ff <= 16'd0;
         gest_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_state_ff <= cur_state_in;
         cand_state_ff <= cand_state_in;
         cand_count_ff <= cand_count_in;
         last_time_ff <= last_time_in;
         committed_ff <= committed_in;
         gest_ff <= gest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_state_ff <= out_state_in;
         out_pev_ff <= out_pev_in;
         out_gev_ff <= out_gev_in;
         out_edist_ff <= out_edist_in;
         out_committed_ff <= out_committed_in;
      end
   end

`ifndef ASSERT_OFF
   // LEFT always collapses on the next beat and cannot be re-entered from there.
   a_left_collapses: assert property (@(posedge clock) disable iff (reset)
      (cur_state_ff == ST_LEFT && accept) |=> (cur_state_ff != ST_LEFT))
      else $error("LEFT state held across two beats");

   // With no person present, no committed distance is kept.
   a_no_person_distance: assert property (@(posedge clock) disable iff (reset)
      (cur_state_ff == ST_NONE || cur_state_ff == ST_LEFT) |-> (committed_ff == 16'd0))
      else $error("committed distance set while no person present");

   // A departure beat reports LEFT with a zero distance.
   a_left_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_presence_event == EV_LEFT) |->
      (rsp_event_distance_mm == 16'd0 && rsp_presence_state == ST_LEFT))
      else $error("departure beat with wrong state or distance");

   // A sensor error beat carries no gesture.
   a_error_no_gesture: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_presence_event == EV_ERROR) |-> (rsp_gesture_event == G_NONE))
      else $error("gesture reported on a sensor error beat");
`endif

endmodule

// ===== tb/tb_proximity_presence_gesture_tracker_top.sv =====
// Self-checking testbench for the proximity presence and gesture tracker top level.
`timescale 1ns / 1ps

module tb_proximity_presence_gesture_tracker_top;
   import ppgt_pkg::*;

   typedef struct packed {
      logic [1:0]  presence_state;
      logic [2:0]  presence_event;
      logic [1:0]  gesture_event;
      logic [15:0] event_mm;
      logic [15:0] committed_mm;
   } tick_result_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_style_type;
   typedef enum int {SC_HOVER, SC_CLOSE_IN, SC_BACK_OFF, SC_JUMP, SC_ABSENT, SC_NOISE}
      scene_type;

   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 300;

   // Mirrors the tracker's registers and state, and keeps the results still owed.
   class presence_scoreboard;
      logic [15:0] max_valid_mm = 16'd1200;
      logic [15:0] nearby_enter_mm = 16'd300;
      logic [15:0] nearby_exit_mm = 16'd400;
      logic [15:0] approach_enter_mm = 16'd800;
      logic [15:0] approach_exit_mm = 16'd1000;
      logic [7:0]  confirm_samples = 8'd3;
      logic [15:0] sample_interval_ms = 16'd50;
      logic        gestures_on = 1'b1;

      logic [1:0]  current_state = ST_NONE;
      logic [1:0]  candidate_state = ST_NONE;
      logic [7:0]  candidate_count = 8'd0;
      logic [31:0] last_sample_time = 32'd0;
      logic [15:0] committed_mm = 16'd0;
      logic [15:0] reference_mm = 16'd0;
      logic [31:0] reference_time = 32'd0;
      logic [31:0] hover_start = 32'd0;
      logic        hover_reported = 1'b0;
      logic [31:0] cooldown_until = 32'd0;

      tick_result_type awaited_results[$];
      int mismatches = 0;
      int results_seen = 0;

      function void write_reg(logic [2:0] index, logic [15:0] value);
         case (index)
            REG_MAX_VALID:       max_valid_mm = value;
            REG_NEARBY_ENTER:    nearby_enter_mm = value;
            REG_NEARBY_EXIT:     nearby_exit_mm = value;
            REG_APPROACH_ENTER:  approach_enter_mm = value;
            REG_APPROACH_EXIT:   approach_exit_mm = value;
            REG_CONFIRM:         confirm_samples = value[7:0];
            REG_SAMPLE_INTERVAL: sample_interval_ms = value;
            REG_GESTURES_EN:     gestures_on = value[0];
            default: ;
         endcase
      endfunction

      // Exit thresholds apply once a state is held, enter thresholds otherwise.
      function logic [1:0] classify(logic [15:0] mm);
         if (mm == 16'd0 || mm > max_valid_mm) return ST_NONE;
         if (current_state == ST_NEAR) begin
            if (mm > approach_exit_mm) return ST_NONE;
            if (mm > nearby_exit_mm) return ST_APPROACH;
            return ST_NEAR;
         end
         if (current_state == ST_APPROACH) begin
            if (mm <= nearby_enter_mm) return ST_NEAR;
            if (mm > approach_exit_mm) return ST_NONE;
            return ST_APPROACH;
         end
         if (mm <= nearby_enter_mm) return ST_NEAR;
         if (mm <= approach_enter_mm) return ST_APPROACH;
         return ST_NONE;
      endfunction

      function logic [1:0] track_gesture(logic [15:0] mm, logic [31:0] now);
         int          delta;
         logic [31:0] held;
         logic [31:0] since_ref;
         logic [1:0]  gesture;
         gesture = G_NONE;
         if (mm == 16'd0 || mm > max_valid_mm) begin
            reference_mm = 16'd0;
            hover_start = 32'd0;
            hover_reported = 1'b0;
            return G_NONE;
         end
         if (reference_mm == 16'd0) begin
            reference_mm = mm;
            reference_time = now;
            hover_start = now;
            return G_NONE;
         end
         delta = int'(mm) - int'(reference_mm);
         if (delta <= int'(HOVER_JITTER_MM) && delta >= -int'(HOVER_JITTER_MM)) begin
            // A hover start time of zero reads as unset, even if zero was a real time.
            if (hover_start == 32'd0) hover_start = now;
            held = now - hover_start;
            if (!hover_reported && mm <= nearby_enter_mm && held >= HOVER_HOLD_MS) begin
               hover_reported = 1'b1;
               gesture = G_HOVER;
            end
         end else begin
            hover_start = now;
            hover_reported = 1'b0;
         end
         since_ref = now - reference_time;
         // The cooldown compare does not wrap, unlike every other time difference.
         if (now < cooldown_until) begin
            if (since_ref > MOVE_WINDOW_MS) begin
               reference_mm = mm;
               reference_time = now;
            end
            return gesture;
         end
         if (since_ref <= MOVE_WINDOW_MS) begin
            if (delta <= -int'(MOVE_THRESHOLD_MM) || delta >= int'(MOVE_THRESHOLD_MM)) begin
               gesture = (delta < 0) ? G_APPROACH : G_RETREAT;
               cooldown_until = now + COOLDOWN_MS;
               reference_mm = mm;
               reference_time = now;
            end
         end else begin
            reference_mm = mm;
            reference_time = now;
         end
         return gesture;
      endfunction

      function void predict_tick(logic [31:0] now, logic [15:0] mm, logic timed_out);
         tick_result_type r;
         logic [31:0]     since;
         logic [1:0]      seen;
         logic [1:0]      prev;
         r = '0;
         r.presence_event = EV_NONE;
         r.gesture_event = G_NONE;
         if (current_state == ST_LEFT) begin
            current_state = ST_NONE;
            candidate_state = ST_NONE;
            candidate_count = 8'd0;
         end
         since = now - last_sample_time;
         if (since >= {16'd0, sample_interval_ms}) begin
            last_sample_time = now;
            if (timed_out) begin
               r.presence_event = EV_ERROR;
            end else begin
               if (gestures_on) begin
                  r.gesture_event = track_gesture(mm, now);
                  if (r.gesture_event != G_NONE) r.event_mm = mm;
               end
               seen = classify(mm);
               if (seen == candidate_state) begin
                  if (candidate_count < COUNT_MAX) candidate_count = candidate_count + 8'd1;
               end else begin
                  candidate_state = seen;
                  candidate_count = 8'd1;
               end
               if (candidate_count >= confirm_samples && seen != current_state) begin
                  prev = current_state;
                  current_state = seen;
                  committed_mm = (seen == ST_NONE) ? 16'd0 : mm;
                  if (seen == ST_NEAR) begin
                     r.presence_event = EV_DETECTED;
                     r.event_mm = mm;
                  end else if (seen == ST_APPROACH) begin
                     if (prev == ST_NONE) begin
                        r.presence_event = EV_APPROACHING;
                        r.event_mm = mm;
                     end
                  end else if (prev != ST_NONE) begin
                     current_state = ST_LEFT;
                     r.presence_event = EV_LEFT;
                     r.event_mm = 16'd0;
                  end
               end
            end
         end
         r.presence_state = current_state;
         r.committed_mm = committed_mm;
         awaited_results.push_back(r);
      endfunction

      function void check_result(tick_result_type got);
         tick_result_type want;
         results_seen++;
         if (awaited_results.size() == 0) begin
            if (mismatches < 10)
               $display("Result beat %0d arrived with no tick outstanding", results_seen);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         if (want.presence_state !== got.presence_state ||
             want.presence_event !== got.presence_event ||
             want.gesture_event !== got.gesture_event ||
             want.event_mm !== got.event_mm ||
             want.committed_mm !== got.committed_mm) begin
            if (mismatches < 10)
               $display("Mismatch on result beat %0d: ", results_seen,
                        "expected state %0d event %0d gesture %0d ",
                        want.presence_state, want.presence_event, want.gesture_event,
                        "event_mm %0d committed_mm %0d, ", want.event_mm, want.committed_mm,
                        "got state %0d event %0d gesture %0d ",
                        got.presence_state, got.presence_event, got.gesture_event,
                        "event_mm %0d committed_mm %0d", got.event_mm, got.committed_mm);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_now_ms = 32'd0;
   logic [15:0] req_distance_mm = 16'd0;
   logic        req_sensor_timeout = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_presence_state;
   logic [2:0]  rsp_presence_event;
   logic [1:0]  rsp_gesture_event;
   logic [15:0] rsp_event_distance_mm;
   logic [15:0] rsp_committed_distance_mm;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = REG_MAX_VALID;
   logic [15:0] csr_wdata = 16'd0;

   presence_scoreboard scoreboard;

   logic         hold_request = 1'b0;
   logic         hold_taken = 1'b0;
   int           hold_left = 0;
   int           rx_cycle = 0;
   rx_style_type rx_style = RX_OPEN;
   int           idle_cycles = 0;

   int          burst_left = 0;
   logic [31:0] tick_now = 32'd0;
   scene_type   scene = SC_NOISE;
   int          scene_left = 0;
   int          scene_mm = 0;
   int          scene_step = 0;

   proximity_presence_gesture_tracker_top dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_now_ms                (req_now_ms),
      .req_distance_mm           (req_distance_mm),
      .req_sensor_timeout        (req_sensor_timeout),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_presence_state        (rsp_presence_state),
      .rsp_presence_event        (rsp_presence_event),
      .rsp_gesture_event         (rsp_gesture_event),
      .rsp_event_distance_mm     (rsp_event_distance_mm),
      .rsp_committed_distance_mm (rsp_committed_distance_mm),
      .csr_wr_en                 (csr_wr_en),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver changes its stall style every so often, and once holds off for
   // a long stretch so that the result register fills and req_ready drops.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 96 == 0) rx_style <= rx_style_type'($urandom_range(0, 3));
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_style)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= (rx_cycle % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_result(tick_result_type'({rsp_presence_state, rsp_presence_event,
                                                    rsp_gesture_event, rsp_event_distance_mm,
                                                    rsp_committed_distance_mm}));
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one tick and holds it until accepted; bursts end in a short gap.
   task automatic send_tick(logic [31:0] now, logic [15:0] mm, logic timed_out);
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_distance_mm <= mm;
      req_sensor_timeout <= timed_out;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scoreboard.predict_tick(now, mm, timed_out);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (scoreboard.awaited_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      scoreboard.write_reg(index, value);
   endtask

   task automatic program_regs(logic [15:0] max_mm, logic [15:0] near_in,
                               logic [15:0] near_out, logic [15:0] appr_in,
                               logic [15:0] appr_out, logic [15:0] confirm,
                               logic [15:0] interval, logic [15:0] gestures);
      settle();
      write_reg(REG_MAX_VALID, max_mm);
      write_reg(REG_NEARBY_ENTER, near_in);
      write_reg(REG_NEARBY_EXIT, near_out);
      write_reg(REG_APPROACH_ENTER, appr_in);
      write_reg(REG_APPROACH_EXIT, appr_out);
      write_reg(REG_CONFIRM, confirm);
      write_reg(REG_SAMPLE_INTERVAL, interval);
      write_reg(REG_GESTURES_EN, gestures);
      csr_wr_en <= 1'b0;
   endtask

   // Ticks follow short scenes: a hand hovering, closing in, backing off, jumping,
   // gone, or plain noise. Timestamps mostly step by about the sample interval.
   task automatic run_ticks(int count, bit near_wrap);
      int          roll;
      int          mm_i;
      logic [15:0] interval;
      if (near_wrap) tick_now = 32'hFFFF_FC00 + $urandom_range(0, 255);
      repeat (count) begin
         if (scene_left == 0) begin
            scene = scene_type'($urandom_range(0, 5));
            case (scene)
               SC_HOVER: begin
                  scene_mm = $urandom_range(40, 420);
                  scene_left = $urandom_range(10, 30);
               end
               SC_CLOSE_IN: begin
                  scene_mm = $urandom_range(400, 1300);
                  scene_step = -int'($urandom_range(10, 120));
                  scene_left = $urandom_range(6, 20);
               end
               SC_BACK_OFF: begin
                  scene_mm = $urandom_range(40, 500);
                  scene_step = $urandom_range(10, 120);
                  scene_left = $urandom_range(6, 20);
               end
               SC_JUMP: begin
                  scene_mm = $urandom_range(200, 1100);
                  scene_step = $urandom_range(0, 1) ? 300 : -300;
                  scene_left = $urandom_range(2, 4);
               end
               SC_ABSENT: scene_left = $urandom_range(3, 8);
               default:   scene_left = $urandom_range(1, 4);
            endcase
         end
         scene_left--;
         case (scene)
            SC_HOVER:  mm_i = scene_mm + int'($urandom_range(0, 50)) - 25;
            SC_ABSENT: mm_i = $urandom_range(0, 1) ? 0 : int'($urandom_range(1300, 65535));
            SC_NOISE:  mm_i = $urandom_range(0, 65535);
            default: begin
               mm_i = scene_mm;
               scene_mm = scene_mm + scene_step;
            end
         endcase
         if (mm_i < 0) mm_i = 0;
         if (mm_i > 65535) mm_i = 65535;
         interval = scoreboard.sample_interval_ms;
         roll = $urandom_range(0, 99);
         if (roll < 8)
            tick_now = tick_now + $urandom_range(0, interval);
         else if (roll < 92)
            tick_now = tick_now + interval + $urandom_range(0, 60);
         else if (roll < 97)
            tick_now = tick_now + $urandom_range(0, 2000);
         else
            tick_now = tick_now + $urandom;
         send_tick(tick_now, 16'(mm_i), ($urandom_range(0, 24) == 0));
      end
   endtask

   initial begin
      scoreboard = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed walk at the reset settings: gating, timeout, range limits, arrival,
      // approach and retreat gestures, a hover, departure and timestamp wrap.
      send_tick(32'd0, 16'd250, 1'b0);
      send_tick(32'd100, 16'd0, 1'b1);
      send_tick(32'd110, 16'hFFFF, 1'b0);
      send_tick(32'd150, 16'hFFFF, 1'b0);
      send_tick(32'd200, 16'd1200, 1'b0);
      send_tick(32'd250, 16'd1201, 1'b0);
      send_tick(32'd300, 16'd800, 1'b0);
      send_tick(32'd350, 16'd790, 1'b0);
      send_tick(32'd400, 16'd780, 1'b0);
      send_tick(32'd450, 16'd300, 1'b0);
      send_tick(32'd500, 16'd290, 1'b0);
      send_tick(32'd550, 16'd280, 1'b0);
      send_tick(32'd900, 16'd285, 1'b0);
      send_tick(32'd1500, 16'd290, 1'b0);
      send_tick(32'd1600, 16'd600, 1'b0);
      send_tick(32'd1650, 16'd610, 1'b0);
      send_tick(32'd1700, 16'd620, 1'b0);
      send_tick(32'd1750, 16'd0, 1'b0);
      send_tick(32'd1800, 16'd0, 1'b0);
      send_tick(32'd1850, 16'd0, 1'b0);
      send_tick(32'd1900, 16'd0, 1'b0);
      send_tick(32'hFFFF_FF00, 16'hFFFF, 1'b0);
      send_tick(32'd0, 16'd500, 1'b0);
      send_tick(32'd60, 16'd510, 1'b0);
      send_tick(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_tick(32'h8000_0000, 16'd1, 1'b0);
      tick_now = 32'h8000_0000;

      program_regs(16'd1200, 16'd300, 16'd400, 16'd800, 16'd1000, 16'd3, 16'd50, 16'd1);
      run_ticks(300, 1'b0);

      program_regs(16'd1200, 16'd300, 16'd400, 16'd800, 16'd1000, 16'd1, 16'd0, 16'd1);
      hold_request <= 1'b1;
      run_ticks(200, 1'b0);

      program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd255, 16'hFFFF, 16'd0);
      run_ticks(150, 1'b1);

      program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
      run_ticks(80, 1'b0);

      // Inconsistent thresholds with immediate commit.
      program_regs(16'd900, 16'd500, 16'd200, 16'd300, 16'd600, 16'd0, 16'd20, 16'd1);
      run_ticks(200, 1'b1);

      repeat (3) begin
         program_regs(16'($urandom_range(600, 2000)), 16'($urandom_range(100, 400)),
                      16'($urandom_range(300, 550)), 16'($urandom_range(500, 900)),
                      16'($urandom_range(800, 1200)),
                      (16'($urandom_range(0, 255)) << 8) | 16'($urandom_range(0, 5)),
                      16'($urandom_range(0, 120)), 16'($urandom));
         run_ticks(170, 1'($urandom_range(0, 1)));
      end

      settle();
      repeat (10) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.awaited_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ppgt_pkg.sv
hdl/ppgt_gesture.sv
hdl/proximity_presence_gesture_tracker_top.sv
tb/tb_proximity_presence_gesture_tracker_top.sv
